[rtl/mmqe_pkg.sv]
// ----------------------------------------------------------------------------
// Market maker quote engine package
// Field widths, stream layout, register indexes, quote modes and the
// command and status bundles shared by the controller and the datapath.
// ----------------------------------------------------------------------------
package mmqe_pkg;

  // Field widths of the stream items.
  localparam int PRICE_WIDTH = 40;
  localparam int IPW        = PRICE_WIDTH;  // price fields
  localparam int SIZE_W     = 32;
  localparam int INV_W      = 48;
  localparam int TIME_W     = 48;
  localparam int REG_W      = 32;  // most configuration registers
  localparam int MODE_W     = 2;
  localparam int LIMB_W     = 32;
  localparam int POS_NUM_W  = 64;  // |inventory| shifted left by 16
  localparam int POS_FRAC   = 16;

  // Input stream layout, lowest bit first.
  localparam int IN_ASK_P_LO  = 0;
  localparam int IN_ASK_S_LO  = IN_ASK_P_LO + IPW;
  localparam int IN_BID_P_LO  = IN_ASK_S_LO + SIZE_W;
  localparam int IN_BID_S_LO  = IN_BID_P_LO + IPW;
  localparam int IN_FAIR_LO   = IN_BID_S_LO + SIZE_W;
  localparam int IN_INV_LO    = IN_FAIR_LO + IPW;
  localparam int IN_NOW_LO    = IN_INV_LO + INV_W;
  localparam int IN_TDATA_W   = 280;

  // Output stream layout, lowest bit first.
  localparam int OUT_ASK_P_LO = 0;
  localparam int OUT_ASK_S_LO = OUT_ASK_P_LO + IPW;
  localparam int OUT_BID_P_LO = OUT_ASK_S_LO + SIZE_W;
  localparam int OUT_BID_S_LO = OUT_BID_P_LO + IPW;
  localparam int OUT_FLAG_BIT = OUT_BID_S_LO + SIZE_W;
  localparam int OUT_USED_W   = OUT_FLAG_BIT + 1;
  localparam int OUT_TDATA_W  = 152;

  // Configuration port.
  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = 48;

  localparam logic [CFG_IDX_W-1:0] CFG_QUOTE_MODE   = 3'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_HALF_SPREAD  = 3'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_TICK_STEP    = 3'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_QUOTE_SIZE   = 3'd3;
  localparam logic [CFG_IDX_W-1:0] CFG_RISK_COEF    = 3'd4;
  localparam logic [CFG_IDX_W-1:0] CFG_MODEL_HALF   = 3'd5;
  localparam logic [CFG_IDX_W-1:0] CFG_HORIZON_MS   = 3'd6;
  localparam logic [CFG_IDX_W-1:0] CFG_FIRST_SETTLE = 3'd7;

  localparam logic [MODE_W-1:0] MODE_TOP   = 2'd0;
  localparam logic [MODE_W-1:0] MODE_MID   = 2'd1;
  localparam logic [MODE_W-1:0] MODE_MODEL = 2'd2;

  localparam logic [REG_W-1:0] HORIZON_RESET = 32'd86400000;
  localparam logic [REG_W-1:0] TICK_RESET    = 32'd1;

  // Last limb index of each multiply pass.
  localparam logic [1:0] POS_LAST_LIMB = 2'd1;
  localparam logic [1:0] P1_LAST_LIMB  = 2'd2;

  typedef struct packed {
    logic       load_in;    // capture the accepted input item
    logic       dl_step;    // load / roll the settlement deadline
    logic       rem_load;   // register remaining time and its flags
    logic       div_start;  // start both dividers, clear the products
    logic       mul_go;     // form one partial product
    logic       acc_go;     // add the partial product into its sum
    logic       mul_phase;  // 0: pos * risk, 1: (pos * risk) * horizon
    logic [1:0] limb;       // limb of the wide operand
    logic       term_load;  // register the saturated position term
    logic       out_load;   // write the quote into the output register
  } cmd_t;

  typedef struct packed {
    logic model_mode;
    logic div_busy;
  } sts_t;

endpackage

[rtl/mmqe_div.sv]
// ----------------------------------------------------------------------------
// Radix-2 divider
// Restoring division, one quotient bit per cycle.
// ----------------------------------------------------------------------------
module mmqe_div #(
  parameter int NUM_W = 64,
  parameter int DEN_W = 40
) (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             start,
  input  logic [NUM_W-1:0] num,
  input  logic [DEN_W-1:0] den,
  output logic             busy,
  output logic [NUM_W-1:0] quot
);

  localparam int CW = $clog2(NUM_W + 1);

  logic [NUM_W-1:0] quo_r;
  logic [DEN_W-1:0] rem_r;
  logic [DEN_W-1:0] den_r;
  logic [CW-1:0]    cnt_r;
  logic             busy_r;

  logic [DEN_W:0]   trial;
  logic [DEN_W:0]   diff;
  logic             ge;

  assign trial = {rem_r, quo_r[NUM_W-1]};
  assign ge    = trial >= {1'b0, den_r};
  assign diff  = trial - {1'b0, den_r};

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      cnt_r  <= '0;
    end else if (start) begin
      busy_r <= 1'b1;
      cnt_r  <= CW'(NUM_W);
    end else if (busy_r) begin
      cnt_r <= cnt_r - CW'(1);
      if (cnt_r == CW'(1)) begin
        busy_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      quo_r <= num;
      rem_r <= '0;
      den_r <= den;
    end else if (busy_r) begin
      quo_r <= {quo_r[NUM_W-2:0], ge};
      rem_r <= ge ? diff[DEN_W-1:0] : trial[DEN_W-1:0];
    end
  end

  assign busy = busy_r;
  assign quot = quo_r;

endmodule

[rtl/mmqe_dp.sv]
// ----------------------------------------------------------------------------
// Quote engine datapath
// Configuration registers, input capture, settlement deadline, the two
// dividers, a 32x33 multiplier with limb accumulation and the quote logic
// with its output register.
// ----------------------------------------------------------------------------
module mmqe_dp #(
  parameter int HORIZON_FRAC_BITS = 24
) (
  input  logic                               clk,
  input  logic                               rst_n,
  input  logic                               cfg_we,
  input  logic [mmqe_pkg::CFG_IDX_W-1:0]     cfg_index,
  input  logic [mmqe_pkg::CFG_DATA_W-1:0]    cfg_wdata,
  input  logic [mmqe_pkg::IN_TDATA_W-1:0]    in_tdata,
  input  mmqe_pkg::cmd_t                     cmd,
  output mmqe_pkg::sts_t                     sts,
  output logic [mmqe_pkg::OUT_TDATA_W-1:0]   out_tdata
);

  import mmqe_pkg::*;

  localparam int RW    = 68;
  localparam int TH_W  = HORIZON_FRAC_BITS + 1;
  localparam int SHIFT = HORIZON_FRAC_BITS + 32;
  localparam logic [RW-1:0] PMAX = (RW'(1) << PRICE_WIDTH) - RW'(1);

  // Configuration registers.
  logic [MODE_W-1:0] mode_r;
  logic [REG_W-1:0]  hs_r;
  logic [REG_W-1:0]  tick_r;
  logic [REG_W-1:0]  qsize_r;
  logic [REG_W-1:0]  risk_r;
  logic [REG_W-1:0]  mhs_r;
  logic [REG_W-1:0]  hor_r;
  logic [TIME_W-1:0] first_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mode_r  <= MODE_MID;
      hs_r    <= '0;
      tick_r  <= TICK_RESET;
      qsize_r <= '0;
      risk_r  <= '0;
      mhs_r   <= '0;
      hor_r   <= HORIZON_RESET;
      first_r <= '0;
    end else if (cfg_we) begin
      unique case (cfg_index)
        CFG_QUOTE_MODE:   mode_r  <= cfg_wdata[MODE_W-1:0];
        CFG_HALF_SPREAD:  hs_r    <= cfg_wdata[REG_W-1:0];
        CFG_TICK_STEP:    tick_r  <= cfg_wdata[REG_W-1:0];
        CFG_QUOTE_SIZE:   qsize_r <= cfg_wdata[REG_W-1:0];
        CFG_RISK_COEF:    risk_r  <= cfg_wdata[REG_W-1:0];
        CFG_MODEL_HALF:   mhs_r   <= cfg_wdata[REG_W-1:0];
        CFG_HORIZON_MS:   hor_r   <= cfg_wdata[REG_W-1:0];
        CFG_FIRST_SETTLE: first_r <= cfg_wdata[TIME_W-1:0];
        default:          mode_r  <= mode_r;
      endcase
    end
  end

  // Input capture. Prices are capped to the price range on the way in.
  logic [IPW-1:0]    ask_raw, bid_raw, fair_raw;
  logic [INV_W-1:0]  inv_raw;
  logic [IPW-1:0]    ask_in_r, bid_in_r, fair_r;
  logic              ask_nz_r, bid_nz_r, neg_r;
  logic [INV_W-1:0]  mag_r;
  logic [TIME_W-1:0] now_r;

  assign ask_raw  = in_tdata[IN_ASK_P_LO +: IPW];
  assign bid_raw  = in_tdata[IN_BID_P_LO +: IPW];
  assign fair_raw = in_tdata[IN_FAIR_LO +: IPW];
  assign inv_raw  = in_tdata[IN_INV_LO +: INV_W];

  always_ff @(posedge clk) begin
    if (cmd.load_in) begin
      ask_in_r <= (RW'(ask_raw) > PMAX) ? PMAX[IPW-1:0] : ask_raw;
      bid_in_r <= (RW'(bid_raw) > PMAX) ? PMAX[IPW-1:0] : bid_raw;
      fair_r   <= (RW'(fair_raw) > PMAX) ? PMAX[IPW-1:0] : fair_raw;
      ask_nz_r <= |in_tdata[IN_ASK_S_LO +: SIZE_W];
      bid_nz_r <= |in_tdata[IN_BID_S_LO +: SIZE_W];
      neg_r    <= inv_raw[INV_W-1];
      mag_r    <= inv_raw[INV_W-1] ? (~inv_raw + INV_W'(1)) : inv_raw;
      now_r    <= in_tdata[IN_NOW_LO +: TIME_W];
    end
  end

  // Settlement deadline: loaded on first use, rolled one horizon when passed.
  logic [TIME_W-1:0] dl_r;
  logic              loaded_r;
  logic [TIME_W-1:0] dl_base, dl_sum, dl_nxt;

  assign dl_base = loaded_r ? dl_r : first_r;
  assign dl_sum  = dl_base + TIME_W'(hor_r);
  assign dl_nxt  = (dl_base <= now_r) ? dl_sum : dl_base;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      dl_r     <= '0;
      loaded_r <= 1'b0;
    end else if (cfg_we && cfg_index == CFG_FIRST_SETTLE) begin
      loaded_r <= 1'b0;
    end else if (cmd.dl_step) begin
      dl_r     <= dl_nxt;
      loaded_r <= 1'b1;
    end
  end

  logic [TIME_W-1:0] remain;
  logic [REG_W-1:0]  rem_r;
  logic              gone_r, full_r;

  assign remain = dl_r - now_r;

  always_ff @(posedge clk) begin
    if (cmd.rem_load) begin
      gone_r <= dl_r <= now_r;
      full_r <= remain >= TIME_W'(hor_r);
      rem_r  <= remain[REG_W-1:0];
    end
  end

  // Dividers: position over fair price, and remaining time over horizon.
  logic                 pos_busy, th_busy;
  logic [POS_NUM_W-1:0] pos_q, th_q;
  logic [TH_W-1:0]      th_val;

  mmqe_div #(.NUM_W(POS_NUM_W), .DEN_W(IPW)) u_div_pos (
    .clk   (clk),
    .rst_n (rst_n),
    .start (cmd.div_start),
    .num   ({mag_r, {POS_FRAC{1'b0}}}),
    .den   (fair_r),
    .busy  (pos_busy),
    .quot  (pos_q)
  );

  mmqe_div #(.NUM_W(POS_NUM_W), .DEN_W(REG_W)) u_div_th (
    .clk   (clk),
    .rst_n (rst_n),
    .start (cmd.div_start),
    .num   (POS_NUM_W'(rem_r) << HORIZON_FRAC_BITS),
    .den   (hor_r),
    .busy  (th_busy),
    .quot  (th_q)
  );

  always_comb begin
    if (gone_r) begin
      th_val = '0;
    end else if (full_r) begin
      th_val = TH_W'(1) << HORIZON_FRAC_BITS;
    end else begin
      th_val = th_q[TH_W-1:0];
    end
  end

  // Limb multiplier: each 32x33 product is registered, then added into its sum before the next one is formed.
  logic [LIMB_W-1:0]   x_limb;
  logic [LIMB_W:0]     y_op;
  logic [2*LIMB_W:0]   mp_r;
  logic [3*LIMB_W-1:0] p1_r;
  logic [4*LIMB_W-1:0] p2_r;
  logic [4*LIMB_W-1:0] mp_sh;

  always_comb begin
    if (cmd.mul_phase) begin
      case (cmd.limb)
        2'd0:    x_limb = p1_r[0 +: LIMB_W];
        2'd1:    x_limb = p1_r[LIMB_W +: LIMB_W];
        default: x_limb = p1_r[2*LIMB_W +: LIMB_W];
      endcase
      y_op = (LIMB_W + 1)'(th_val);
    end else begin
      x_limb = cmd.limb[0] ? pos_q[LIMB_W +: LIMB_W] : pos_q[0 +: LIMB_W];
      y_op   = {1'b0, risk_r};
    end
  end

  always_comb begin
    case (cmd.limb)
      2'd0:    mp_sh = (4*LIMB_W)'(mp_r);
      2'd1:    mp_sh = (4*LIMB_W)'(mp_r) << LIMB_W;
      default: mp_sh = (4*LIMB_W)'(mp_r) << (2*LIMB_W);
    endcase
  end

  always_ff @(posedge clk) begin
    if (cmd.mul_go) begin
      mp_r <= {{(LIMB_W+1){1'b0}}, x_limb} * {{LIMB_W{1'b0}}, y_op};
    end
    if (cmd.div_start) begin
      p1_r <= '0;
      p2_r <= '0;
    end else if (cmd.acc_go) begin
      if (cmd.mul_phase) begin
        p2_r <= p2_r + mp_sh;
      end else begin
        p1_r <= p1_r + mp_sh[3*LIMB_W-1:0];
      end
    end
  end

  // Position term: product scaled down, saturated to 64 bits.
  logic [4*LIMB_W-1:0] p2_hi;
  logic [2*LIMB_W-1:0] term_r;
  logic                fair_zero;

  assign p2_hi     = p2_r >> SHIFT;
  assign fair_zero = fair_r == '0;

  always_ff @(posedge clk) begin
    if (cmd.term_load) begin
      if (fair_zero) begin
        term_r <= '0;
      end else if (|p2_hi[4*LIMB_W-1:2*LIMB_W]) begin
        term_r <= '1;
      end else begin
        term_r <= p2_hi[2*LIMB_W-1:0];
      end
    end
  end

  // Quote formation.
  function automatic logic [RW-1:0] clamp_fn(input logic signed [RW-1:0] v);
    logic [RW-1:0] r;
    if (v < 0) begin
      r = '0;
    end else if ($unsigned(v) > PMAX) begin
      r = PMAX;
    end else begin
      r = $unsigned(v);
    end
    return r;
  endfunction

  logic                 is_model, is_top;
  logic [RW-1:0]        fair_w, spread_w;
  logic signed [RW-1:0] sterm, ask_lin, bid_lin;
  logic [RW-1:0]        ask_lim, bid_lim;
  logic [RW-1:0]        ask_w, bid_w, tick_w;
  logic [RW-1:0]        step_ask, step_bid;
  logic                 flag;

  assign is_model = mode_r == MODE_MODEL;
  assign is_top   = mode_r == MODE_TOP;
  assign fair_w   = RW'(fair_r);
  assign spread_w = is_model ? RW'(mhs_r) : RW'(hs_r);
  assign tick_w   = RW'(tick_r);

  always_comb begin
    if (!is_model) begin
      sterm = '0;
    end else if (neg_r) begin
      sterm = $signed(RW'(term_r));
    end else begin
      sterm = -$signed(RW'(term_r));
    end
    ask_lin = $signed(fair_w) + $signed(spread_w) + sterm;
    bid_lin = $signed(fair_w) - $signed(spread_w) + sterm;
    ask_lim = clamp_fn(ask_lin);
    bid_lim = clamp_fn(bid_lin);

    // Top of book: step one tick inside each non-empty side, then bound
    // by the fair price band.
    if (!ask_nz_r) begin
      step_ask = RW'(ask_in_r);
    end else if (RW'(ask_in_r) >= tick_w) begin
      step_ask = RW'(ask_in_r) - tick_w;
    end else begin
      step_ask = '0;
    end
    step_bid = bid_nz_r ? RW'(bid_in_r) + tick_w : RW'(bid_in_r);

    if (is_top) begin
      ask_w = (step_ask > ask_lim) ? step_ask : ask_lim;
      bid_w = (step_bid < bid_lim) ? step_bid : bid_lim;
    end else begin
      ask_w = ask_lim;
      bid_w = bid_lim;
    end
    flag = is_model && fair_zero;
  end

  logic [OUT_TDATA_W-1:0] out_r;

  always_ff @(posedge clk) begin
    if (cmd.out_load) begin
      out_r <= OUT_TDATA_W'({flag, qsize_r, bid_w[IPW-1:0], qsize_r, ask_w[IPW-1:0]});
    end
  end

  assign out_tdata      = out_r;
  assign sts.model_mode = is_model;
  assign sts.div_busy   = pos_busy | th_busy;

endmodule

[rtl/mmqe_ctrl.sv]
// ----------------------------------------------------------------------------
// Quote engine controller
// Sequences one item through deadline update, division and limb multiplies
// (model mode only) and quote formation, and owns both stream handshakes.
// ----------------------------------------------------------------------------
module mmqe_ctrl (
  input  logic           clk,
  input  logic           rst_n,
  input  logic           in_tvalid,
  output logic           in_tready,
  output logic           out_tvalid,
  input  logic           out_tready,
  input  mmqe_pkg::sts_t sts,
  output mmqe_pkg::cmd_t cmd
);

  import mmqe_pkg::*;

  localparam logic [3:0] S_IDLE   = 4'd0;
  localparam logic [3:0] S_DEAD   = 4'd1;
  localparam logic [3:0] S_REM    = 4'd2;
  localparam logic [3:0] S_DSTART = 4'd3;
  localparam logic [3:0] S_DIV    = 4'd4;
  localparam logic [3:0] S_MULA   = 4'd5;
  localparam logic [3:0] S_MULB   = 4'd6;
  localparam logic [3:0] S_TERM   = 4'd7;
  localparam logic [3:0] S_RES    = 4'd8;

  logic [3:0] state_r, state_nxt;
  logic [1:0] limb_r, limb_nxt;
  logic       phase_r, phase_nxt;
  logic       out_valid_r, out_valid_nxt;

  always_comb begin
    state_nxt = state_r;
    limb_nxt  = limb_r;
    phase_nxt = phase_r;
    cmd       = '0;
    cmd.limb      = limb_r;
    cmd.mul_phase = phase_r;

    unique case (state_r)
      S_IDLE: begin
        if (in_tvalid) begin
          cmd.load_in = 1'b1;
          state_nxt   = sts.model_mode ? S_DEAD : S_RES;
        end
      end
      S_DEAD: begin
        cmd.dl_step = 1'b1;
        state_nxt   = S_REM;
      end
      S_REM: begin
        cmd.rem_load = 1'b1;
        state_nxt    = S_DSTART;
      end
      S_DSTART: begin
        cmd.div_start = 1'b1;
        limb_nxt      = '0;
        phase_nxt     = 1'b0;
        state_nxt     = S_DIV;
      end
      S_DIV: begin
        if (!sts.div_busy) begin
          state_nxt = S_MULA;
        end
      end
      S_MULA: begin
        cmd.mul_go = 1'b1;
        state_nxt  = S_MULB;
      end
      S_MULB: begin
        cmd.acc_go = 1'b1;
        state_nxt  = S_MULA;
        if (!phase_r && limb_r == POS_LAST_LIMB) begin
          phase_nxt = 1'b1;
          limb_nxt  = '0;
        end else if (phase_r && limb_r == P1_LAST_LIMB) begin
          state_nxt = S_TERM;
        end else begin
          limb_nxt = limb_r + 2'd1;
        end
      end
      S_TERM: begin
        cmd.term_load = 1'b1;
        state_nxt     = S_RES;
      end
      S_RES: begin
        // The quote waits here while the previous one is still held.
        if (!out_valid_r || out_tready) begin
          cmd.out_load = 1'b1;
          state_nxt    = S_IDLE;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_comb begin
    if (cmd.out_load) begin
      out_valid_nxt = 1'b1;
    end else if (out_tready) begin
      out_valid_nxt = 1'b0;
    end else begin
      out_valid_nxt = out_valid_r;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      limb_r      <= '0;
      phase_r     <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      limb_r      <= limb_nxt;
      phase_r     <= phase_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  assign in_tready  = state_r == S_IDLE;
  assign out_tvalid = out_valid_r;

endmodule

[rtl/market_maker_quote_engine_unit.sv]
// ----------------------------------------------------------------------------
// Market maker quote engine
// Turns one market update into a two-sided quote: top of book, mid, or an
// inventory-skewed model quote with a rolling settlement deadline.
//
//   Channel   Direction  Handshake          Payload
//   in_*      input      tvalid / tready    in_tdata, 280 bits
//   out_*     output     tvalid / tready    out_tdata, 152 bits
//   cfg_*     input      cfg_we only        cfg_index, cfg_wdata
//
// Top of book and mid quotes are formed from the captured input and written
// into the output register once it is free. Model quotes first run the two
// radix-2 dividers side by side, followed by five 32x33 limb multiplies.
// One item is in work at a time; a new item is taken while the previous
// quote still waits in the output register.
// Reset (rst_n low, synchronous) restores register defaults and clears the
// loaded settlement deadline.
// ----------------------------------------------------------------------------
module market_maker_quote_engine_unit #(
  parameter int HORIZON_FRAC_BITS = 24
) (
  input  logic                             clk,
  input  logic                             rst_n,
  // book_ask_price, book_ask_size, book_bid_price, book_bid_size,
  // fair_price, inventory, now_ms
  input  logic [mmqe_pkg::IN_TDATA_W-1:0]  in_tdata,
  input  logic                             in_tvalid,
  output logic                             in_tready,
  // ask_price, ask_size, bid_price, bid_size, zero_fair_flag, zero fill
  output logic [mmqe_pkg::OUT_TDATA_W-1:0] out_tdata,
  output logic                             out_tvalid,
  input  logic                             out_tready,
  input  logic                             cfg_we,
  input  logic [mmqe_pkg::CFG_IDX_W-1:0]   cfg_index,
  input  logic [mmqe_pkg::CFG_DATA_W-1:0]  cfg_wdata
);

  import mmqe_pkg::*;

  cmd_t cmd;
  sts_t sts;

  mmqe_ctrl u_ctrl (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .sts        (sts),
    .cmd        (cmd)
  );

  mmqe_dp #(
    .HORIZON_FRAC_BITS (HORIZON_FRAC_BITS)
  ) u_dp (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_wdata (cfg_wdata),
    .in_tdata  (in_tdata),
    .cmd       (cmd),
    .sts       (sts),
    .out_tdata (out_tdata)
  );

endmodule

[rtl/mmqe_checker.sv]
// ----------------------------------------------------------------------------
// Quote engine port checker
// Watches the top-level ports for handshake and sequencing slips.
// ----------------------------------------------------------------------------
module mmqe_checker (
  input logic                             clk,
  input logic                             rst_n,
  input logic                             in_tvalid,
  input logic                             in_tready,
  input logic [mmqe_pkg::OUT_TDATA_W-1:0] out_tdata,
  input logic                             out_tvalid,
  input logic                             out_tready,
  input logic                             cfg_we
);

  import mmqe_pkg::*;

  // A stalled quote stays valid and unchanged.
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tready |=> out_tvalid && $stable(out_tdata))
    else $error("stalled quote dropped or changed");

  // Only one item is in work: ready drops right after a transfer.
  a_one_item: assert property (@(posedge clk) disable iff (!rst_n)
    in_tvalid && in_tready |=> !in_tready)
    else $error("second item taken while one is in work");

  // Both quote sides carry the same size.
  a_sizes: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid |-> out_tdata[OUT_ASK_S_LO +: SIZE_W] == out_tdata[OUT_BID_S_LO +: SIZE_W])
    else $error("ask and bid sizes differ");

  // Registers are written only while the engine is idle and empty.
  a_cfg_idle: assert property (@(posedge clk) disable iff (!rst_n)
    cfg_we |-> in_tready && !out_tvalid)
    else $error("register written while an item is in flight");

  // Reset leaves the block empty and ready.
  a_reset: assert property (@(posedge clk)
    !rst_n |=> !out_tvalid && in_tready)
    else $error("block not idle after reset");

endmodule

bind market_maker_quote_engine_unit mmqe_checker u_mmqe_checker (
  .clk        (clk),
  .rst_n      (rst_n),
  .in_tvalid  (in_tvalid),
  .in_tready  (in_tready),
  .out_tdata  (out_tdata),
  .out_tvalid (out_tvalid),
  .out_tready (out_tready),
  .cfg_we     (cfg_we)
);

[sim/market_maker_quote_engine_unit_test.sv]
// ----------------------------------------------------------------------------
// Market maker quote engine testbench
// Drives market updates into the quote engine and checks every quote
// against a predictor kept inside the bench. It covers the top of book,
// mid and inventory-skewed model modes, the settlement deadline roll,
// price saturation and zero fair price. Both stream sides idle at random,
// and the run includes a long output stall and sender pauses.
// ----------------------------------------------------------------------------
module market_maker_quote_engine_unit_test;
  import mmqe_pkg::*;

  localparam int FRAC_BITS = 24;
  localparam int TH_W = FRAC_BITS + 1;
  localparam int IDLE_GAP = 10;
  localparam int END_GAP = 100;
  localparam int MAX_PRINTED = 30;
  localparam longint LIMIT_CYCLES = 3000000;

  localparam logic [MODE_W-1:0] MODE_SPARE = 2'd3;
  localparam logic [IPW-1:0] PRICE_MAX = '1;
  localparam logic [INV_W-1:0] INV_MIN = {1'b1, {(INV_W-1){1'b0}}};
  localparam logic [INV_W-1:0] INV_MAX = {1'b0, {(INV_W-1){1'b1}}};
  localparam logic [TIME_W-1:0] TIME_MAX = '1;
  localparam logic [REG_W-1:0] REG_MAX = '1;

  typedef struct {
    logic [IPW-1:0]           ask_p;
    logic [SIZE_W-1:0]        ask_s;
    logic [IPW-1:0]           bid_p;
    logic [SIZE_W-1:0]        bid_s;
    logic [IPW-1:0]           fair;
    logic signed [INV_W-1:0]  inv;
    logic [TIME_W-1:0]        now;
  } update_t;

  typedef struct {
    logic [IPW-1:0]    ask_p;
    logic [SIZE_W-1:0] ask_s;
    logic [IPW-1:0]    bid_p;
    logic [SIZE_W-1:0] bid_s;
    logic              flag;
  } quote_t;

  logic                   clk;
  logic                   rst_n;
  logic [IN_TDATA_W-1:0]  in_tdata;
  logic                   in_tvalid;
  logic                   in_tready;
  logic [OUT_TDATA_W-1:0] out_tdata;
  logic                   out_tvalid;
  logic                   out_tready;
  logic                   cfg_we;
  logic [CFG_IDX_W-1:0]   cfg_index;
  logic [CFG_DATA_W-1:0]  cfg_wdata;

  // Register copies and deadline state of the predictor.
  logic [MODE_W-1:0] cfg_mode;
  logic [REG_W-1:0]  cfg_half;
  logic [REG_W-1:0]  cfg_tick;
  logic [REG_W-1:0]  cfg_size;
  logic [REG_W-1:0]  cfg_risk;
  logic [REG_W-1:0]  cfg_mhs;
  logic [REG_W-1:0]  cfg_horizon;
  logic [TIME_W-1:0] cfg_first;
  logic [TIME_W-1:0] settle_deadline;
  bit                deadline_loaded;

  quote_t quote_q[$];
  int error_count = 0;
  int quotes_checked = 0;
  int n_top = 0, n_mid = 0, n_model = 0, n_zero_fair = 0, phases_run = 0;
  int hold_request = 0;
  bit sender_calm = 1'b0;
  bit receiver_calm = 1'b0;

  market_maker_quote_engine_unit dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_tdata  (in_tdata),
    .in_tvalid (in_tvalid),
    .in_tready (in_tready),
    .out_tdata (out_tdata),
    .out_tvalid(out_tvalid),
    .out_tready(out_tready),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_wdata (cfg_wdata)
  );

  initial clk = 1'b0;
  always #4 clk = ~clk;

  // --------------------------------------------------------------------------
  // Predictor
  // --------------------------------------------------------------------------
  function automatic logic [IPW-1:0] clamp_price(input logic signed [69:0] v);
    if (v < 0) return '0;
    if (v > PRICE_MAX) return PRICE_MAX;
    return v[IPW-1:0];
  endfunction

  // Loads and rolls the deadline, then returns the remaining fraction of
  // the horizon in Q1.24.
  function automatic logic [TH_W-1:0] horizon_fraction(input logic [TIME_W-1:0] now);
    logic [TIME_W-1:0] remain;
    logic [95:0]       num;
    if (!deadline_loaded) begin
      settle_deadline = cfg_first;
      deadline_loaded = 1'b1;
    end
    if (settle_deadline <= now) settle_deadline = settle_deadline + TIME_W'(cfg_horizon);
    if (settle_deadline <= now) return '0;
    remain = settle_deadline - now;
    if (remain >= TIME_W'(cfg_horizon)) return {1'b1, {FRAC_BITS{1'b0}}};
    num = 96'(remain) << FRAC_BITS;
    return TH_W'(num / 96'(cfg_horizon));
  endfunction

  function automatic logic [63:0] position_term(input logic [INV_W-1:0] mag,
                                                input logic [IPW-1:0] fair,
                                                input logic [TH_W-1:0] th);
    logic [63:0]  pos;
    logic [127:0] prod;
    pos = {mag, 16'h0000} / 64'(fair);
    prod = 128'(pos) * 128'(cfg_risk);
    prod = (prod * 128'(th)) >> (FRAC_BITS + 32);
    if (prod[127:64] != 0) return '1;
    return prod[63:0];
  endfunction

  function automatic quote_t predict_quote(input update_t u);
    quote_t            q;
    logic [63:0]       floor_ask, ceil_bid, step_w, ask_w, bid_w, term;
    logic [INV_W-1:0]  mag;
    logic [TH_W-1:0]   th;
    logic signed [69:0] f, h, t;
    q.ask_s = cfg_size;
    q.bid_s = cfg_size;
    q.flag = 1'b0;
    f = u.fair;
    case (cfg_mode)
      MODE_TOP: begin
        n_top++;
        floor_ask = 64'(u.fair) + 64'(cfg_half);
        if (u.ask_s != 0)
          step_w = (64'(u.ask_p) >= 64'(cfg_tick)) ? 64'(u.ask_p) - 64'(cfg_tick) : 64'd0;
        else
          step_w = 64'(u.ask_p);
        ask_w = (step_w > floor_ask) ? step_w : floor_ask;
        q.ask_p = clamp_price(ask_w);
        if (64'(cfg_half) <= 64'(u.fair)) begin
          ceil_bid = 64'(u.fair) - 64'(cfg_half);
          step_w = (u.bid_s != 0) ? 64'(u.bid_p) + 64'(cfg_tick) : 64'(u.bid_p);
          bid_w = (step_w < ceil_bid) ? step_w : ceil_bid;
        end else begin
          bid_w = '0;
        end
        q.bid_p = bid_w[IPW-1:0];
      end
      MODE_MODEL: begin
        n_model++;
        th = horizon_fraction(u.now);
        mag = u.inv[INV_W-1] ? (~u.inv + 1'b1) : u.inv;
        term = '0;
        if (u.fair == 0) begin
          q.flag = 1'b1;
          n_zero_fair++;
        end else begin
          term = position_term(mag, u.fair, th);
        end
        h = cfg_mhs;
        t = term;
        // A short position skews both sides up, a long one skews them down.
        if (u.inv[INV_W-1]) begin
          q.ask_p = clamp_price(f + h + t);
          q.bid_p = clamp_price(f + t - h);
        end else begin
          q.ask_p = clamp_price(f + h - t);
          q.bid_p = clamp_price(f - h - t);
        end
      end
      default: begin
        n_mid++;
        h = cfg_half;
        q.ask_p = clamp_price(f + h);
        q.bid_p = clamp_price(f - h);
      end
    endcase
    return q;
  endfunction

  // --------------------------------------------------------------------------
  // Stimulus helpers
  // --------------------------------------------------------------------------
  function automatic logic [IN_TDATA_W-1:0] pack_update(input update_t u);
    logic [IN_TDATA_W-1:0] d;
    d = '0;
    d[IN_ASK_P_LO +: IPW]   = u.ask_p;
    d[IN_ASK_S_LO +: SIZE_W] = u.ask_s;
    d[IN_BID_P_LO +: IPW]   = u.bid_p;
    d[IN_BID_S_LO +: SIZE_W] = u.bid_s;
    d[IN_FAIR_LO +: IPW]    = u.fair;
    d[IN_INV_LO +: INV_W]   = u.inv;
    d[IN_NOW_LO +: TIME_W]  = u.now;
    return d;
  endfunction

  function automatic update_t mk_update(input logic [IPW-1:0] ask_p,
                                        input logic [SIZE_W-1:0] ask_s,
                                        input logic [IPW-1:0] bid_p,
                                        input logic [SIZE_W-1:0] bid_s,
                                        input logic [IPW-1:0] fair,
                                        input logic [INV_W-1:0] inv,
                                        input logic [TIME_W-1:0] now);
    update_t u;
    u.ask_p = ask_p;
    u.ask_s = ask_s;
    u.bid_p = bid_p;
    u.bid_s = bid_s;
    u.fair = fair;
    u.inv = inv;
    u.now = now;
    return u;
  endfunction

  function automatic logic [IPW-1:0] rand_price();
    case ($urandom_range(0, 7))
      0: return '0;
      1: return PRICE_MAX;
      2: return IPW'($urandom_range(1, 1000));
      3: return PRICE_MAX - IPW'($urandom_range(0, 1000));
      4: return IPW'({$urandom, $urandom}) >> $urandom_range(0, 39);
      default: return IPW'({$urandom, $urandom});
    endcase
  endfunction

  function automatic logic [SIZE_W-1:0] rand_size();
    case ($urandom_range(0, 3))
      0: return '0;
      1: return '1;
      default: return $urandom;
    endcase
  endfunction

  function automatic logic [INV_W-1:0] rand_inventory();
    logic signed [INV_W-1:0] v;
    case ($urandom_range(0, 7))
      0: v = '0;
      1: v = INV_MAX;
      2: v = INV_MIN;
      3: v = INV_W'($urandom_range(0, 2000)) - 1000;
      4, 5: begin
        v = INV_W'({$urandom, $urandom}) >> $urandom_range(0, 46);
        if ($urandom_range(0, 1) == 1) v = -v;
      end
      default: v = INV_W'({$urandom, $urandom});
    endcase
    return v;
  endfunction

  function automatic logic [TIME_W-1:0] rand_time();
    case ($urandom_range(0, 5))
      0: return '0;
      1: return TIME_MAX;
      2: return TIME_W'($urandom_range(0, 10000));
      default: return TIME_W'({$urandom, $urandom});
    endcase
  endfunction

  // Most timestamps land around the live deadline so that the roll and the
  // fractional horizon are reached often.
  function automatic logic [TIME_W-1:0] pick_now();
    logic [63:0] h, base, off;
    if ($urandom_range(0, 9) < 2) return rand_time();
    h = (cfg_horizon == 0) ? 64'd16 : 64'(cfg_horizon);
    base = deadline_loaded ? 64'(settle_deadline) : 64'(cfg_first);
    off = {$urandom, $urandom} % (3 * h);
    return TIME_W'(base + off - 2 * h);
  endfunction

  function automatic logic [REG_W-1:0] rand_reg();
    case ($urandom_range(0, 9))
      0: return '0;
      1: return REG_MAX;
      2: return $urandom_range(1, 16);
      3, 4, 5: return $urandom >> $urandom_range(0, 31);
      default: return $urandom;
    endcase
  endfunction

  function automatic logic [REG_W-1:0] rand_risk();
    case ($urandom_range(0, 7))
      0: return '0;
      1: return REG_MAX;
      default: return $urandom >> $urandom_range(0, 31);
    endcase
  endfunction

  function automatic logic [REG_W-1:0] rand_horizon();
    case ($urandom_range(0, 9))
      0: return '0;
      1: return 32'd1;
      2: return REG_MAX;
      3, 4, 5: return $urandom_range(1, 2000);
      default: return $urandom >> $urandom_range(0, 24);
    endcase
  endfunction

  function automatic update_t rand_update();
    update_t        u;
    logic [IPW:0]   sum;
    logic [IPW-1:0] off;
    u.fair = rand_price();
    if ($urandom_range(0, 3) == 0) begin
      u.ask_p = rand_price();
      u.bid_p = rand_price();
    end else begin
      off = IPW'($urandom >> $urandom_range(4, 31));
      sum = u.fair + off;
      u.ask_p = sum[IPW] ? PRICE_MAX : sum[IPW-1:0];
      off = IPW'($urandom >> $urandom_range(4, 31));
      u.bid_p = (u.fair >= off) ? u.fair - off : '0;
    end
    u.ask_s = rand_size();
    u.bid_s = rand_size();
    u.inv = rand_inventory();
    u.now = pick_now();
    return u;
  endfunction

  function automatic int pick_gap();
    int r;
    if (sender_calm) return 0;
    r = $urandom_range(0, 99);
    if (r < 60) return 0;
    if (r < 95) return $urandom_range(1, 3);
    return $urandom_range(10, 40);
  endfunction

  // --------------------------------------------------------------------------
  // Bus tasks
  // --------------------------------------------------------------------------
  // Valid stays high across back-to-back transfers; this task only drops it for a gap.
  task automatic send_update(input update_t u);
    int gap;
    gap = pick_gap();
    @(negedge clk);
    if (gap > 0) begin
      in_tvalid <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    in_tdata <= pack_update(u);
    in_tvalid <= 1'b1;
    @(posedge clk);
    while (!in_tready) @(posedge clk);
    quote_q.push_back(predict_quote(u));
  endtask

  task automatic wait_quotes_done(input int settle);
    @(negedge clk);
    in_tvalid <= 1'b0;
    while (quote_q.size() != 0) @(posedge clk);
    repeat (settle) @(posedge clk);
  endtask

  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx,
                           input logic [CFG_DATA_W-1:0] value);
    @(negedge clk);
    cfg_we <= 1'b1;
    cfg_index <= idx;
    cfg_wdata <= value;
    @(negedge clk);
    cfg_we <= 1'b0;
    case (idx)
      CFG_QUOTE_MODE:   cfg_mode = value[MODE_W-1:0];
      CFG_HALF_SPREAD:  cfg_half = value[REG_W-1:0];
      CFG_TICK_STEP:    cfg_tick = value[REG_W-1:0];
      CFG_QUOTE_SIZE:   cfg_size = value[REG_W-1:0];
      CFG_RISK_COEF:    cfg_risk = value[REG_W-1:0];
      CFG_MODEL_HALF:   cfg_mhs = value[REG_W-1:0];
      CFG_HORIZON_MS:   cfg_horizon = value[REG_W-1:0];
      CFG_FIRST_SETTLE: begin
        cfg_first = value[TIME_W-1:0];
        deadline_loaded = 1'b0;
      end
      default: ;
    endcase
  endtask

  task automatic randomize_registers(input logic [MODE_W-1:0] mode);
    write_reg(CFG_QUOTE_MODE, mode);
    write_reg(CFG_HALF_SPREAD, rand_reg());
    write_reg(CFG_TICK_STEP, rand_reg());
    write_reg(CFG_QUOTE_SIZE, rand_reg());
    write_reg(CFG_RISK_COEF, rand_risk());
    write_reg(CFG_MODEL_HALF, rand_reg());
    write_reg(CFG_HORIZON_MS, rand_horizon());
    // Skipping the deadline write sometimes lets the deadline carry over.
    if ($urandom_range(0, 3) != 0) write_reg(CFG_FIRST_SETTLE, rand_time());
  endtask

  task automatic run_random_phase(input logic [MODE_W-1:0] mode, input int count);
    wait_quotes_done(IDLE_GAP);
    randomize_registers(mode);
    sender_calm = ($urandom_range(0, 4) == 0);
    receiver_calm = ($urandom_range(0, 4) == 0);
    phases_run++;
    repeat (count) send_update(rand_update());
  endtask

  // --------------------------------------------------------------------------
  // Result checking
  // --------------------------------------------------------------------------
  task automatic report_error(input string msg);
    error_count++;
    if (error_count <= MAX_PRINTED) $display("ERROR at %0t: %s", $time, msg);
  endtask

  task automatic check_field(input string name, input logic [63:0] got,
                             input logic [63:0] want);
    if (got !== want)
      report_error($sformatf("quote %0d %s: got %h, want %h",
                             quotes_checked, name, got, want));
  endtask

  always @(posedge clk) begin : check_quotes
    quote_t want;
    if (rst_n && out_tvalid && out_tready) begin
      if (quote_q.size() == 0) begin
        report_error("quote transfer with no update pending");
      end else begin
        want = quote_q.pop_front();
        check_field("ask_price", out_tdata[OUT_ASK_P_LO +: IPW], want.ask_p);
        check_field("ask_size", out_tdata[OUT_ASK_S_LO +: SIZE_W], want.ask_s);
        check_field("bid_price", out_tdata[OUT_BID_P_LO +: IPW], want.bid_p);
        check_field("bid_size", out_tdata[OUT_BID_S_LO +: SIZE_W], want.bid_s);
        check_field("zero_fair_flag", out_tdata[OUT_FLAG_BIT], want.flag);
        check_field("padding", out_tdata[OUT_TDATA_W-1:OUT_USED_W], '0);
        quotes_checked++;
      end
    end
  end

  // Output ready: random stalls, calm stretches, and long hold-offs on request.
  initial begin : drive_ready
    int stall_left;
    int r;
    stall_left = 0;
    forever begin
      @(negedge clk);
      if (hold_request > 0) begin
        stall_left = hold_request;
        hold_request = 0;
      end
      if (stall_left > 0) begin
        out_tready <= 1'b0;
        stall_left--;
      end else if (receiver_calm) begin
        out_tready <= 1'b1;
      end else begin
        r = $urandom_range(0, 99);
        if (r < 70) begin
          out_tready <= 1'b1;
        end else begin
          out_tready <= 1'b0;
          stall_left = (r < 97) ? $urandom_range(0, 3) : $urandom_range(10, 60);
        end
      end
    end
  end

  // --------------------------------------------------------------------------
  // Tests
  // --------------------------------------------------------------------------
  task automatic test_reset_defaults();
    // Mid mode with a zero spread and zero size comes out of reset.
    send_update(mk_update(40'd1200, 32'd5, 40'd800, 32'd5, 40'd1000, 48'd10, 48'd0));
    send_update(mk_update(PRICE_MAX, 32'd0, 40'd0, 32'd0, PRICE_MAX, INV_MIN, TIME_MAX));
    wait_quotes_done(IDLE_GAP);
    write_reg(CFG_QUOTE_MODE, MODE_TOP);
    send_update(mk_update(40'd1200, 32'd5, 40'd800, 32'd5, 40'd1000, 48'd0, 48'd0));
    wait_quotes_done(IDLE_GAP);
    write_reg(CFG_QUOTE_MODE, MODE_MODEL);
    send_update(mk_update(40'd0, 32'd0, 40'd0, 32'd0, 40'd1000, 48'd5000, 48'd100));
    send_update(mk_update(40'd0, 32'd0, 40'd0, 32'd0, 40'd0, 48'd5000, 48'd200));
  endtask

  task automatic test_directed_book_and_mid();
    wait_quotes_done(IDLE_GAP);
    write_reg(CFG_QUOTE_MODE, MODE_MID);
    write_reg(CFG_HALF_SPREAD, REG_MAX);
    write_reg(CFG_QUOTE_SIZE, REG_MAX);
    send_update(mk_update(40'd0, 32'd0, 40'd0, 32'd0, 40'd0, 48'd0, 48'd0));
    send_update(mk_update(40'd0, 32'd0, 40'd0, 32'd0, PRICE_MAX, 48'd0, 48'd0));
    wait_quotes_done(IDLE_GAP);
    // The unused mode code quotes like mid.
    write_reg(CFG_QUOTE_MODE, MODE_SPARE);
    write_reg(CFG_HALF_SPREAD, 32'd100);
    send_update(mk_update(40'd5000, 32'd1, 40'd10, 32'd1, 40'd1000, 48'd0, 48'd0));
    wait_quotes_done(IDLE_GAP);
    write_reg(CFG_QUOTE_MODE, MODE_TOP);
    write_reg(CFG_HALF_SPREAD, 32'd10);
    write_reg(CFG_TICK_STEP, 32'd5);
    write_reg(CFG_QUOTE_SIZE, 32'd0);
    // Ask step would go below zero; bid step runs past the price range.
    send_update(mk_update(40'd3, 32'd1, PRICE_MAX, REG_MAX, 40'd500, 48'd0, 48'd0));
    // Both sides empty: book prices pass through unstepped.
    send_update(mk_update(40'd2000, 32'd0, 40'd100, 32'd0, 40'd1000, 48'd0, 48'd0));
    send_update(mk_update(40'd1100, 32'd1, 40'd900, 32'd1, 40'd1000, 48'd0, 48'd0));
    // Fair below the half spread leaves the bid at zero.
    send_update(mk_update(40'd1100, 32'd1, 40'd900, 32'd1, 40'd4, 48'd0, 48'd0));
    wait_quotes_done(IDLE_GAP);
    write_reg(CFG_TICK_STEP, REG_MAX);
    write_reg(CFG_HALF_SPREAD, 32'd0);
    send_update(mk_update(PRICE_MAX, 32'd1, 40'd0, 32'd1, PRICE_MAX >> 1, 48'd0, 48'd0));
    wait_quotes_done(IDLE_GAP);
    write_reg(CFG_TICK_STEP, 32'd0);
    send_update(mk_update(PRICE_MAX, 32'd1, 40'd0, 32'd1, PRICE_MAX >> 1, 48'd0, 48'd0));
  endtask

  task automatic test_directed_model();
    wait_quotes_done(IDLE_GAP);
    write_reg(CFG_QUOTE_MODE, MODE_MODEL);
    write_reg(CFG_RISK_COEF, 32'h0001_0000);
    write_reg(CFG_MODEL_HALF, 32'd7);
    write_reg(CFG_HORIZON_MS, 32'd100);
    write_reg(CFG_FIRST_SETTLE, 48'd1000);
    // Deadline load, then a fractional horizon, a roll, and a missed roll.
    send_update(mk_update(40'd0, 32'd0, 40'd0, 32'd0, 40'd500, 48'd1000, 48'd900));
    send_update(mk_update(40'd0, 32'd0, 40'd0, 32'd0, 40'd500, -48'sd1000, 48'd950));
    send_update(mk_update(40'd0, 32'd0, 40'd0, 32'd0, 40'd500, 48'd1000, 48'd1000));
    send_update(mk_update(40'd0, 32'd0, 40'd0, 32'd0, 40'd500, 48'd1000, 48'd5000));
    send_update(mk_update(40'd0, 32'd0, 40'd0, 32'd0, 40'd0, 48'd1000, 48'd1150));
    wait_quotes_done(IDLE_GAP);
    write_reg(CFG_RISK_COEF, REG_MAX);
    send_update(mk_update(40'd0, 32'd0, 40'd0, 32'd0, 40'd1, INV_MIN, 48'd1150));
    send_update(mk_update(40'd0, 32'd0, 40'd0, 32'd0, 40'd1, INV_MAX, 48'd1150));
    // Deadline far ahead of now: full horizon.
    send_update(mk_update(40'd0, 32'd0, 40'd0, 32'd0, PRICE_MAX, INV_MAX, 48'd0));
    wait_quotes_done(IDLE_GAP);
    write_reg(CFG_RISK_COEF, 32'h0000_0100);
    write_reg(CFG_HORIZON_MS, 32'd0);
    write_reg(CFG_FIRST_SETTLE, TIME_MAX);
    // A zero horizon length: full horizon while ahead, none once passed.
    send_update(mk_update(40'd0, 32'd0, 40'd0, 32'd0, 40'd4096, 48'd9000, 48'd10));
    send_update(mk_update(40'd0, 32'd0, 40'd0, 32'd0, 40'd4096, 48'd9000, TIME_MAX));
    wait_quotes_done(IDLE_GAP);
    write_reg(CFG_HORIZON_MS, REG_MAX);
    // The roll wraps around the top of the time range.
    send_update(mk_update(40'd0, 32'd0, 40'd0, 32'd0, 40'd4096, -48'sd9000, TIME_MAX));
    send_update(mk_update(40'd0, 32'd0, 40'd0, 32'd0, 40'd4096, -48'sd9000, 48'd0));
    wait_quotes_done(IDLE_GAP);
    write_reg(CFG_MODEL_HALF, REG_MAX);
    write_reg(CFG_RISK_COEF, 32'd0);
    send_update(mk_update(40'd0, 32'd0, 40'd0, 32'd0, PRICE_MAX, 48'd0, 48'd0));
    send_update(mk_update(40'd0, 32'd0, 40'd0, 32'd0, 40'd5, 48'd0, 48'd0));
  endtask

  task automatic test_random_top();
    repeat (20) run_random_phase(MODE_TOP, 25);
  endtask

  task automatic test_random_mid();
    repeat (10) run_random_phase(($urandom_range(0, 3) == 0) ? MODE_SPARE : MODE_MID, 35);
  endtask

  task automatic test_random_model();
    repeat (30) run_random_phase(MODE_MODEL, 30);
  endtask

  // The receiver holds off long enough for the engine to fill and stall input.
  task automatic test_output_backpressure();
    wait_quotes_done(IDLE_GAP);
    randomize_registers(MODE_MID);
    sender_calm = 1'b1;
    receiver_calm = 1'b0;
    hold_request = 300;
    repeat (40) send_update(rand_update());
    sender_calm = 1'b0;
  endtask

  // The sender stops until every quote is back before each new burst.
  task automatic test_sender_pause();
    wait_quotes_done(IDLE_GAP);
    randomize_registers(MODE_MODEL);
    receiver_calm = 1'b0;
    repeat (5) begin
      repeat (6) send_update(rand_update());
      wait_quotes_done(0);
    end
  endtask

  initial begin : watchdog
    #(LIMIT_CYCLES * 8);
    $display("DONE: errors detected");
    $finish;
  end

  initial begin : main_sequence
    rst_n = 1'b0;
    in_tdata = '0;
    in_tvalid = 1'b0;
    out_tready = 1'b0;
    cfg_we = 1'b0;
    cfg_index = '0;
    cfg_wdata = '0;
    cfg_mode = MODE_MID;
    cfg_half = '0;
    cfg_tick = TICK_RESET;
    cfg_size = '0;
    cfg_risk = '0;
    cfg_mhs = '0;
    cfg_horizon = HORIZON_RESET;
    cfg_first = '0;
    settle_deadline = '0;
    deadline_loaded = 1'b0;
    repeat (12) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    test_reset_defaults();
    test_directed_book_and_mid();
    test_directed_model();
    test_random_top();
    test_random_mid();
    test_random_model();
    test_output_backpressure();
    test_sender_pause();
    wait_quotes_done(END_GAP);

    $display("Covered %0d quotes: %0d top of book, %0d mid, %0d model (%0d zero fair).",
             quotes_checked, n_top, n_mid, n_model, n_zero_fair);
    $display("Ran %0d random register settings, a long output stall and sender pauses.",
             phases_run);
    if (error_count == 0) begin
      $display("DONE: 0 errors");
    end else begin
      $display("DONE: errors detected");
    end
    $finish;
  end

endmodule

[filelist.f]
rtl/mmqe_pkg.sv
rtl/mmqe_div.sv
rtl/mmqe_dp.sv
rtl/mmqe_ctrl.sv
rtl/market_maker_quote_engine_unit.sv
rtl/mmqe_checker.sv
sim/market_maker_quote_engine_unit_test.sv
